// ===== design/assert_macros.svh =====
// Concurrent assertion helpers included by the hash table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that cond never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/ohash_pkg.sv =====
`default_nettype none

package ohash_pkg;

  localparam int unsigned SLOTS  = 256;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RST = LIMIT_W'(192);

  localparam logic [OP_W-1:0] OP_GET = 2'd0;
  localparam logic [OP_W-1:0] OP_SET = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== design/ohash_if.sv =====
`default_nettype none

interface ohash_req_if import ohash_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [KEY_W-1:0]     key_id;
  logic [HASH_W-1:0]    key_hash;
  logic [VALUE_W-1:0]   new_value;

  modport source (output valid, operation, key_id, key_hash, new_value, input ready);
  modport sink   (input valid, operation, key_id, key_hash, new_value, output ready);
endinterface

interface ohash_rsp_if import ohash_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 flag;
  logic [VALUE_W-1:0]   read_value;
  logic                 table_full;

  modport source (output valid, flag, read_value, table_full, input ready);
  modport sink   (input valid, flag, read_value, table_full, output ready);
endinterface

interface ohash_cfg_if import ohash_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LIMIT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/open_addressing_hash_table_core.sv =====
// Channel   Dir   Contents
// req_i     in    operation, key_id, key_hash, new_value
// rsp_o     out   flag, read_value, table_full
// cfg_i     in    fill_limit
//
// A request is handled in steps: the block accepts it and issues the first
// slot read, then probes one slot at a time (1 to 256 slots) through the slot
// memory, and then loads the result into the output register. Requests that
// need no probe skip the probing. Reset empties the table at once
// through per-slot valid flops. A new request is accepted while the previous
// result still waits in the output register.
`default_nettype none

`include "assert_macros.svh"

module open_addressing_hash_table_core import ohash_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ohash_req_if.sink    req_i,
  ohash_rsp_if.source  rsp_o,
  ohash_cfg_if.sink    cfg_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  state_e               state_q;
  logic [OP_W-1:0]      op_q;
  logic [KEY_W-1:0]     key_q;
  logic [VALUE_W-1:0]   val_q;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic [SLOT_W-1:0]    n_q;
  logic                 has_tomb_q;
  logic [SLOT_W-1:0]    tomb_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 pend_flag_q, pend_full_q;
  logic [VALUE_W-1:0]   pend_rd_q;
  logic                 out_valid_q, out_flag_q, out_full_q;
  logic [VALUE_W-1:0]   out_rd_q;

  slot_t                mem [SLOTS];
  slot_t                rd_q;
  logic                 rd_vld_q;
  logic [SLOTS-1:0]     valid_q;

  status_e              st_cur;
  logic                 hit, is_empty, last, done, tomb_first, any_tomb, room;
  logic [SLOT_W-1:0]    tomb_at;
  logic                 wr_en, cnt_inc, res_flag, res_full;
  logic [SLOT_W-1:0]    wr_addr;
  status_e              wr_status;
  logic [VALUE_W-1:0]   res_rd;
  logic                 accept, trivial, out_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_load    = (state_q == S_EMIT) && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.flag       = out_flag_q;
  assign rsp_o.read_value = out_rd_q;
  assign rsp_o.table_full = out_full_q;

  assign trivial = !((req_i.operation == OP_SET) ||
                     (((req_i.operation == OP_GET) || (req_i.operation == OP_DEL)) &&
                      (cnt_q != '0)));

  always_comb begin
    case (state_q)
      S_IDLE:  idx_d = req_i.key_hash[SLOT_W-1:0];
      S_PROBE: idx_d = idx_q + SLOT_W'(1);
      default: idx_d = idx_q;
    endcase
  end

  always_comb begin
    st_cur = ST_EMPTY;
    if (rd_vld_q) begin
      case (rd_q.status)
        ST_LIVE: st_cur = ST_LIVE;
        ST_TOMB: st_cur = ST_TOMB;
        default: st_cur = ST_EMPTY;
      endcase
    end
    hit        = (st_cur == ST_LIVE) && (rd_q.key == key_q);
    is_empty   = (st_cur == ST_EMPTY);
    last       = (n_q == SLOT_W'(SLOTS - 1));
    done       = hit || is_empty || last;
    tomb_first = !has_tomb_q && (st_cur == ST_TOMB);
    any_tomb   = has_tomb_q || tomb_first;
    tomb_at    = has_tomb_q ? tomb_q : idx_q;
    room       = (({1'b0, cnt_q} + (CNT_W + 1)'(1)) <= (CNT_W + 1)'(limit_q));

    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_status = ST_LIVE;
    cnt_inc   = 1'b0;
    res_flag  = 1'b0;
    res_full  = 1'b0;
    res_rd    = '0;
    case (op_q)
      OP_GET: begin
        res_flag = hit;
        res_rd   = hit ? rd_q.value : '0;
      end
      OP_SET: begin
        if (hit) begin
          wr_en = 1'b1;
        end else if (any_tomb) begin
          wr_en    = 1'b1;
          wr_addr  = tomb_at;
          res_flag = 1'b1;
        end else if (is_empty && room) begin
          wr_en    = 1'b1;
          cnt_inc  = 1'b1;
          res_flag = 1'b1;
        end else begin
          res_full = 1'b1;
        end
      end
      OP_DEL: begin
        if (hit) begin
          wr_en     = 1'b1;
          wr_status = ST_TOMB;
          res_flag  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!((state_q == S_PROBE) && done)) begin
      wr_en   = 1'b0;
      cnt_inc = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= mem[idx_d];
    if (wr_en) begin
      mem[wr_addr] <= '{status: wr_status, key: key_q, value: val_q};
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (accept) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key_id;
      val_q <= req_i.new_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[idx_d];
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      has_tomb_q  <= 1'b0;
      tomb_q      <= '0;
      cnt_q       <= '0;
      limit_q     <= FILL_LIMIT_RST;
      pend_flag_q <= 1'b0;
      pend_full_q <= 1'b0;
      pend_rd_q   <= '0;
      out_valid_q <= 1'b0;
      out_flag_q  <= 1'b0;
      out_full_q  <= 1'b0;
      out_rd_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        limit_q <= cfg_i.data;
      end
      if (cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_flag_q  <= pend_flag_q;
        out_full_q  <= pend_full_q;
        out_rd_q    <= pend_rd_q;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            n_q        <= '0;
            has_tomb_q <= 1'b0;
            if (trivial) begin
              pend_flag_q <= 1'b0;
              pend_full_q <= 1'b0;
              pend_rd_q   <= '0;
              state_q     <= S_EMIT;
            end else begin
              state_q <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (done) begin
            pend_flag_q <= res_flag;
            pend_full_q <= res_full;
            pend_rd_q   <= res_rd;
            state_q     <= S_EMIT;
          end else begin
            n_q <= n_q + SLOT_W'(1);
            if (tomb_first) begin
              has_tomb_q <= 1'b1;
              tomb_q     <= idx_q;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_write_outside_probe, clk_i, rst_ni, wr_en && (state_q != S_PROBE))
  `ASSERT_CLK(a_count_steps_by_one, clk_i, rst_ni,
    (cnt_q != $past(cnt_q)) |-> (cnt_q == ($past(cnt_q) + CNT_W'(1))))
  `ASSERT_CLK(a_result_from_emit, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))

endmodule

`default_nettype wire

// ===== tb/tb_open_addressing_hash_table_core.sv =====
`timescale 1ns / 100ps

module tb_open_addressing_hash_table_core;
  import ohash_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int POOL_SIZE = 48;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 242;

  typedef struct {
    logic               flag;
    logic [VALUE_W-1:0] read_value;
    logic               table_full;
  } reply_t;

  class hash_slot_mirror;
    status_e              slot_state [SLOTS];
    logic [KEY_W-1:0]     slot_key [SLOTS];
    logic [VALUE_W-1:0]   slot_value [SLOTS];
    logic [CNT_W-1:0]     used_count;
    logic [LIMIT_W-1:0]   fill_limit;
    reply_t               replies_due [$];
    int                   mismatches;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = ST_EMPTY;
        slot_key[i] = '0;
        slot_value[i] = '0;
      end
      used_count = '0;
      fill_limit = FILL_LIMIT_RST;
      mismatches = 0;
    endfunction

    function bit probe(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
                       output int hit, output bit has_tomb, output int tomb,
                       output bit has_free, output int free_slot);
      int idx;
      idx = int'(hash % SLOTS);
      hit = 0;
      tomb = 0;
      free_slot = 0;
      has_tomb = 1'b0;
      has_free = 1'b0;
      for (int n = 0; n < SLOTS; n++) begin
        if (slot_state[idx] == ST_EMPTY) begin
          has_free = 1'b1;
          free_slot = idx;
          return 1'b0;
        end
        if (slot_state[idx] == ST_LIVE) begin
          if (slot_key[idx] == key) begin
            hit = idx;
            return 1'b1;
          end
        end else if (!has_tomb) begin
          has_tomb = 1'b1;
          tomb = idx;
        end
        idx = (idx + 1) % SLOTS;
      end
      return 1'b0;
    endfunction

    function void accept_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [HASH_W-1:0] hash,
                                 input logic [VALUE_W-1:0] value);
      reply_t r;
      bit found, has_tomb, has_free;
      int hit, tomb, free_slot;
      r.flag = 1'b0;
      r.read_value = '0;
      r.table_full = 1'b0;
      case (op)
        OP_GET: begin
          if (used_count != 0) begin
            found = probe(key, hash, hit, has_tomb, tomb, has_free, free_slot);
            if (found) begin
              r.flag = 1'b1;
              r.read_value = slot_value[hit];
            end
          end
        end
        OP_SET: begin
          found = probe(key, hash, hit, has_tomb, tomb, has_free, free_slot);
          if (found) begin
            slot_value[hit] = value;
          end else if (has_tomb) begin
            slot_state[tomb] = ST_LIVE;
            slot_key[tomb] = key;
            slot_value[tomb] = value;
            r.flag = 1'b1;
          end else if (has_free && int'(used_count) + 1 <= int'(fill_limit)) begin
            slot_state[free_slot] = ST_LIVE;
            slot_key[free_slot] = key;
            slot_value[free_slot] = value;
            used_count = used_count + 1'b1;
            r.flag = 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
        OP_DEL: begin
          if (used_count != 0) begin
            found = probe(key, hash, hit, has_tomb, tomb, has_free, free_slot);
            if (found) begin
              slot_state[hit] = ST_TOMB;
              r.flag = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void compare_reply(input logic flag, input logic [VALUE_W-1:0] read_value,
                                input logic table_full);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply: flag %0b read_value %h table_full %0b",
                 $time, flag, read_value, table_full);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (flag !== want.flag) begin
        $display("%0t: flag expected %0b actual %0b", $time, want.flag, flag);
        mismatches++;
      end
      if (read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value, read_value);
        mismatches++;
      end
      if (table_full !== want.table_full) begin
        $display("%0t: table_full expected %0b actual %0b", $time, want.table_full,
                 table_full);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ohash_req_if req_if();
  ohash_rsp_if rsp_if();
  ohash_cfg_if cfg_if();

  open_addressing_hash_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  hash_slot_mirror table_mirror = new();

  bit                idle_on;
  int                rsp_hold_cycles;
  int unsigned       cycle_count;
  logic [KEY_W-1:0]  pool_key [POOL_SIZE];
  logic [HASH_W-1:0] pool_hash [POOL_SIZE];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver: checks every reply, idles in short bursts and, when asked,
  // holds off for a long stretch so that the block fills up.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        table_mirror.compare_reply(rsp_if.flag, rsp_if.read_value, rsp_if.table_full);
      end
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [HASH_W-1:0] hash,
                              input logic [VALUE_W-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.key_id <= key;
    req_if.key_hash <= hash;
    req_if.new_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    table_mirror.accept_request(op, key, hash, value);
  endtask

  task automatic write_fill_limit(input logic [LIMIT_W-1:0] limit);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= limit;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    table_mirror.fill_limit = limit;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (table_mirror.replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Keys share hashes whose low byte falls in a narrow window, so probes
  // collide, run through tombstones and sometimes wrap past the last slot.
  function automatic void refill_pool();
    int base;
    logic [HASH_W-1:0] h;
    base = $urandom_range(0, 255);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = $urandom;
      h = $urandom;
      h[7:0] = 8'(base + $urandom_range(0, 23));
      pool_hash[i] = h;
    end
  endfunction

  task automatic random_request();
    int r;
    int k;
    int s;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [HASH_W-1:0] hash;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, POOL_SIZE - 1);
    s = $urandom_range(0, 99);
    op = (s < 45) ? OP_SET : (s < 80) ? OP_GET : OP_DEL;
    key = pool_key[k];
    hash = pool_hash[k];
    if (r < 8) begin
      op = OP_W'($urandom);
      key = $urandom;
      hash = $urandom;
    end else if (r < 13) begin
      hash = $urandom;
    end
    send_request(op, key, hash, {$urandom, $urandom});
  endtask

  function automatic logic [LIMIT_W-1:0] phase_limit(input int p);
    case (p)
      0: return 8'd255;
      1: return 8'd1;
      2: return 8'd120;
      3: return 8'd200;
      4: return 8'd64;
      default: return 8'd255;
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    idle_on = 1'b1;
    rsp_hold_cycles = 0;
    req_if.valid <= 1'b0;
    req_if.operation <= OP_GET;
    req_if.key_id <= '0;
    req_if.key_hash <= '0;
    req_if.new_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_GET, 32'h0, 32'h0, 64'h0);
    send_request(OP_DEL, 32'h0, 32'h0, '1);
    send_request(OP_SET, 32'h0, 32'h0, 64'h0);
    send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_request(OP_SET, 32'h5, 32'hA5A5_A5FF, {$urandom, $urandom});
    send_request(OP_GET, 32'h5, 32'hA5A5_A5FF, 64'h0);
    send_request(OP_SET, 32'h0, 32'h0, {$urandom, $urandom});
    send_request(OP_GET, 32'h0, 32'h0, 64'h0);
    send_request(OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
    send_request(OP_SET, 32'h7, 32'h0000_00FF, {$urandom, $urandom});
    send_request(OP_NONE, $urandom, $urandom, {$urandom, $urandom});
    send_request(OP_GET, 32'h7, 32'h0000_00FF, 64'h0);
    send_request(OP_DEL, 32'h7, 32'h0000_00FF, 64'h0);
    send_request(OP_DEL, 32'h7, 32'h0000_00FF, 64'h0);
    drain();

    write_fill_limit(8'd4);
    send_request(OP_SET, 32'h9, 32'h0000_0010, {$urandom, $urandom});
    send_request(OP_SET, 32'hA, 32'h0000_0011, {$urandom, $urandom});
    drain();

    // With the limit at zero only tombstone reuse and overwrites succeed.
    write_fill_limit(8'd0);
    send_request(OP_SET, 32'hB, 32'h0000_0020, {$urandom, $urandom});
    send_request(OP_SET, 32'hC, 32'h0000_00FF, {$urandom, $urandom});
    send_request(OP_SET, 32'h9, 32'h0000_0010, {$urandom, $urandom});
    send_request(OP_GET, 32'hA, 32'h0000_0011, 64'h0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_fill_limit(phase_limit(p));
      idle_on = (p != PHASES - 1);
      if (p == 2) begin
        rsp_hold_cycles = 80;
      end
      refill_pool();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_request();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (table_mirror.mismatches == 0 && table_mirror.replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
